// File: hw/rtl/accel_peak_step_counter_defines.svh
// ----------------------------------------------------------------------------
// accel_peak_step_counter_defines
// assertion macros used by the step counter top level
// ----------------------------------------------------------------------------
`ifndef ACCEL_PEAK_STEP_COUNTER_DEFINES_SVH
`define ACCEL_PEAK_STEP_COUNTER_DEFINES_SVH

// same-cycle implication
`define APSC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("apsc assertion failed");

// next-cycle implication
`define APSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("apsc assertion failed");

`endif

// File: hw/rtl/apsc_pkg.sv
// ----------------------------------------------------------------------------
// apsc_pkg
// widths, constants, types and helper functions of the step counter
// ----------------------------------------------------------------------------
package apsc_pkg;

   localparam int SAMPLE_BITS = 20;
   localparam int FRAC_BITS   = 12;

   localparam int ROOT_W      = SAMPLE_BITS + (SAMPLE_BITS % 2);
   localparam int SUM_W       = 2 * ROOT_W;
   localparam int REM_W       = ROOT_W + 2;
   localparam int SQRT_CYCLES = ROOT_W / 2;
   localparam int SQRT_CNT_W  = $clog2(SQRT_CYCLES);
   localparam logic [SQRT_CNT_W-1:0] SQRT_LAST = SQRT_CNT_W'(SQRT_CYCLES - 1);

   localparam int UNIT_SHIFT = 2 * FRAC_BITS + 4;
   localparam int CMP_W      = (SUM_W > UNIT_SHIFT) ? SUM_W : UNIT_SHIFT + 1;
   localparam logic [CMP_W-1:0] UNIT_LIMIT = CMP_W'(1) << UNIT_SHIFT;

   localparam int ALPHA_W    = 16;
   localparam int THRESH_W   = 20;
   localparam int INTERVAL_W = 16;
   localparam int TIME_W     = 32;
   localparam int COUNT_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam int CMPT_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
   localparam int ACC_W  = SAMPLE_BITS + ALPHA_W + 1;
   localparam logic [ALPHA_W:0]   ALPHA_ONE   = (ALPHA_W + 1)'(1) << ALPHA_W;
   localparam logic [ALPHA_W-1:0] ALPHA_ROUND = ALPHA_W'(1) << (ALPHA_W - 1);

   localparam int G_SCALE_W     = 13;
   localparam int G_SCALE_SHIFT = 16;
   localparam int SCALED_W      = SAMPLE_BITS + G_SCALE_SHIFT + 1;
   localparam logic [G_SCALE_W-1:0]     G_SCALE_Q16 = 13'd6683;
   localparam logic [G_SCALE_SHIFT-1:0] G_SCALE_ROUND = G_SCALE_SHIFT'(1) << (G_SCALE_SHIFT - 1);

   localparam logic [ALPHA_W-1:0]    ALPHA_RESET    = 16'd55706;
   localparam logic [THRESH_W-1:0]   THRESH_RESET   = 20'd4710;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd250;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ALPHA    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_THRESHOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL_MS = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QCNT_W-1:0] QUEUE_FULL_COUNT = QCNT_W'(QUEUE_DEPTH);

   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic [TIME_W-1:0] stamp;
   } sample_entry_type;

   typedef struct packed {
      logic             valid;
      sample_entry_type entry;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_state_type;

   function automatic logic [SAMPLE_BITS-1:0] abs_sample(logic [SAMPLE_BITS-1:0] v);
      logic [SAMPLE_BITS-1:0] r;
      r = v[SAMPLE_BITS-1] ? (~v + SAMPLE_BITS'(1)) : v;
      return r;
   endfunction

   // one restoring digit of the square root
   function automatic sqrt_state_type sqrt_step(sqrt_state_type s, logic [1:0] pair);
      logic [REM_W-1:0] rem_t;
      logic [REM_W-1:0] trial;
      sqrt_state_type   r;
      rem_t = {s.rem[REM_W-3:0], pair};
      trial = {s.root, 2'b01};
      if (rem_t >= trial) begin
         r.rem  = rem_t - trial;
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = rem_t;
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/apsc_front.sv
// ----------------------------------------------------------------------------
// apsc_front
// accepts samples and forms the sum of squares with one shared multiplier
// ----------------------------------------------------------------------------
module apsc_front import apsc_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   input  logic [TIME_W-1:0]             req_timestamp_ms,
   output push_type                      push_out,
   input  queue_status_type              queue_status
);

   localparam logic [1:0] PHASE_PUSH = 2'd3;

   logic                     busy_ff, busy_in;
   logic [1:0]               phase_ff, phase_in;
   logic [SAMPLE_BITS-1:0]   mag_ff [3];
   logic [SAMPLE_BITS-1:0]   mag_in [3];
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [TIME_W-1:0]        stamp_ff, stamp_in;
   logic [2*SAMPLE_BITS-1:0] square;
   logic                     accept;

   assign accept    = req_valid && !busy_ff;
   assign req_stall = busy_ff;
   assign square    = (2*SAMPLE_BITS)'(mag_ff[0]) * (2*SAMPLE_BITS)'(mag_ff[0]);

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      mag_in   = mag_ff;
      sum_in   = sum_ff;
      stamp_in = stamp_ff;
      if (accept) begin
         busy_in   = 1'b1;
         phase_in  = 2'd0;
         sum_in    = '0;
         mag_in[0] = abs_sample(req_accel_x);
         mag_in[1] = abs_sample(req_accel_y);
         mag_in[2] = abs_sample(req_accel_z);
         stamp_in  = req_timestamp_ms;
      end else if (busy_ff) begin
         if (phase_ff != PHASE_PUSH) begin
            sum_in    = sum_ff + SUM_W'(square);
            mag_in[0] = mag_ff[1];
            mag_in[1] = mag_ff[2];
            phase_in  = phase_ff + 2'd1;
         end else if (!queue_status.full) begin
            busy_in = 1'b0;
         end
      end
   end

   assign push_out.valid       = busy_ff && (phase_ff == PHASE_PUSH);
   assign push_out.entry.sum   = sum_ff;
   assign push_out.entry.stamp = stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      sum_ff   <= sum_in;
      stamp_ff <= stamp_in;
   end

endmodule

// File: hw/rtl/apsc_queue.sv
// ----------------------------------------------------------------------------
// apsc_queue
// short fifo of squared sums between the front and the back
// ----------------------------------------------------------------------------
module apsc_queue import apsc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push_in,
   input  logic             pop,
   output queue_status_type status,
   output sample_entry_type head
);

   sample_entry_type  entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              write, read;

   assign status.full  = (count_ff == QUEUE_FULL_COUNT);
   assign status.empty = (count_ff == '0);
   assign head         = entries_ff[rd_ptr_ff];
   assign write        = push_in.valid && !status.full;
   assign read         = pop && !status.empty;

   always_comb begin
      wr_ptr_in = write ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = read ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (write && !read) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (read && !write) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write) begin
         entries_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

endmodule

// File: hw/rtl/apsc_back.sv
// ----------------------------------------------------------------------------
// apsc_back
// square root, unit scaling, low-pass filter and peak detection
// ----------------------------------------------------------------------------
module apsc_back import apsc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  sample_entry_type       head,
   input  queue_status_type       queue_status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COUNT_W-1:0]     rsp_step_total,
   output logic                   rsp_step_now,
   output logic [SAMPLE_BITS-1:0] rsp_filtered_magnitude
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SQRT  = 3'd1;
   localparam logic [2:0] ST_SCALE = 3'd2;
   localparam logic [2:0] ST_FILT1 = 3'd3;
   localparam logic [2:0] ST_FILT2 = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [ALPHA_W-1:0]     alpha_ff, alpha_in;
   logic [THRESH_W-1:0]    thresh_ff, thresh_in;
   logic [INTERVAL_W-1:0]  interval_ff, interval_in;
   logic [2:0]             state_ff, state_in;
   logic                   seen_ff, seen_in;
   logic                   scale_ff, scale_in;
   logic [SAMPLE_BITS-1:0] cur_ff, cur_in;
   logic [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic [SAMPLE_BITS-1:0] older_ff, older_in;
   logic [TIME_W-1:0]      last_ff, last_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]     rsp_total_ff, rsp_total_in;
   logic                   rsp_now_ff, rsp_now_in;
   logic [SAMPLE_BITS-1:0] rsp_filt_ff, rsp_filt_in;

   logic [SQRT_CNT_W-1:0]      cnt_ff, cnt_in;
   sqrt_state_type             sq_ff, sq_in;
   logic [SUM_W-1:0]           rad_ff, rad_in;
   logic [TIME_W-1:0]          stamp_ff, stamp_in;
   logic                       big_ff, big_in;
   logic [SAMPLE_BITS-1:0]     mag_ff, mag_in;
   logic [SAMPLE_BITS+ALPHA_W-1:0] prod_ff, prod_in;
   logic [SAMPLE_BITS-1:0]     filt_ff, filt_in;

   sqrt_state_type         sq_mid, sq_end;
   logic [SCALED_W-1:0]    scaled;
   logic [ALPHA_W:0]       beta;
   logic [ACC_W-1:0]       mix, acc;
   logic [SAMPLE_BITS-1:0] older_n, prev_n;
   logic [TIME_W-1:0]      elapsed;
   logic                   local_max, above, enough, step, out_free;

   assign pop      = (state_ff == ST_IDLE) && !queue_status.empty;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      sq_mid  = sqrt_step(sq_ff, rad_ff[SUM_W-1 -: 2]);
      sq_end  = sqrt_step(sq_mid, rad_ff[SUM_W-3 -: 2]);
      scaled  = SCALED_W'(sq_ff.root[SAMPLE_BITS-1:0]) * SCALED_W'(G_SCALE_Q16)
                + SCALED_W'(G_SCALE_ROUND);
      beta    = ALPHA_ONE - {1'b0, alpha_ff};
      mix     = ACC_W'(beta) * ACC_W'(mag_ff);
      acc     = ACC_W'(prod_ff) + mix + ACC_W'(ALPHA_ROUND);
      older_n = seen_ff ? prev_ff : filt_ff;
      prev_n  = seen_ff ? cur_ff : filt_ff;
      elapsed = stamp_ff - last_ff;
      local_max = (prev_n > older_n) && (prev_n > filt_ff);
      above     = CMPT_W'(prev_n) > CMPT_W'(thresh_ff);
      enough    = elapsed >= TIME_W'(interval_ff);
      step      = local_max && above && enough;
   end

   always_comb begin
      alpha_in     = alpha_ff;
      thresh_in    = thresh_ff;
      interval_in  = interval_ff;
      state_in     = state_ff;
      seen_in      = seen_ff;
      scale_in     = scale_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      older_in     = older_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_total_in = rsp_total_ff;
      rsp_now_in   = rsp_now_ff;
      rsp_filt_in  = rsp_filt_ff;
      cnt_in       = cnt_ff;
      sq_in        = sq_ff;
      rad_in       = rad_ff;
      stamp_in     = stamp_ff;
      big_in       = big_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      filt_in      = filt_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_FILTER_ALPHA:    alpha_in    = csr_data[ALPHA_W-1:0];
            CSR_PEAK_THRESHOLD:  thresh_in   = csr_data[THRESH_W-1:0];
            CSR_MIN_INTERVAL_MS: interval_in = csr_data[INTERVAL_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               rad_in   = head.sum;
               stamp_in = head.stamp;
               sq_in    = '0;
               cnt_in   = '0;
               big_in   = CMP_W'(head.sum) > UNIT_LIMIT;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sq_in  = sq_end;
            rad_in = rad_ff << 4;
            cnt_in = cnt_ff + SQRT_CNT_W'(1);
            if (cnt_ff == SQRT_LAST) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (seen_ff ? scale_ff : big_ff) begin
               mag_in = scaled[SAMPLE_BITS+G_SCALE_SHIFT-1:G_SCALE_SHIFT];
            end else begin
               mag_in = sq_ff.root[SAMPLE_BITS-1:0];
            end
            if (!seen_ff) begin
               scale_in = big_ff;
            end
            state_in = ST_FILT1;
         end
         ST_FILT1: begin
            prod_in  = (SAMPLE_BITS+ALPHA_W)'(alpha_ff) * (SAMPLE_BITS+ALPHA_W)'(cur_ff);
            state_in = ST_FILT2;
         end
         ST_FILT2: begin
            filt_in  = seen_ff ? acc[SAMPLE_BITS+ALPHA_W-1:ALPHA_W] : mag_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               older_in = older_n;
               prev_in  = prev_n;
               cur_in   = filt_ff;
               seen_in  = 1'b1;
               if (step) begin
                  count_in = count_ff + COUNT_W'(1);
                  last_in  = stamp_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_total_in = step ? count_ff + COUNT_W'(1) : count_ff;
               rsp_now_in   = step;
               rsp_filt_in  = filt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_step_total         = rsp_total_ff;
   assign rsp_step_now           = rsp_now_ff;
   assign rsp_filtered_magnitude = rsp_filt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ALPHA_RESET;
         thresh_ff    <= THRESH_RESET;
         interval_ff  <= INTERVAL_RESET;
         state_ff     <= ST_IDLE;
         seen_ff      <= 1'b0;
         scale_ff     <= 1'b0;
         cur_ff       <= '0;
         prev_ff      <= '0;
         older_ff     <= '0;
         last_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alpha_ff     <= alpha_in;
         thresh_ff    <= thresh_in;
         interval_ff  <= interval_in;
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         scale_ff     <= scale_in;
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         older_ff     <= older_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_total_ff <= rsp_total_in;
      rsp_now_ff   <= rsp_now_in;
      rsp_filt_ff  <= rsp_filt_in;
      cnt_ff       <= cnt_in;
      sq_ff        <= sq_in;
      rad_ff       <= rad_in;
      stamp_ff     <= stamp_in;
      big_ff       <= big_in;
      mag_ff       <= mag_in;
      prod_ff      <= prod_in;
      filt_ff      <= filt_in;
   end

endmodule

// File: hw/rtl/accel_peak_step_counter.sv
// ----------------------------------------------------------------------------
// accel_peak_step_counter
// the front handles one sample at a time and stalls requests until its sum is queued
// the back end sets the rate: it pops an entry only when idle and forms two root bits
// per square root step; a 2-entry queue decouples the front from the back
// reset: synchronous; registers return to defaults, history and count clear
// ----------------------------------------------------------------------------
`include "accel_peak_step_counter_defines.svh"

module accel_peak_step_counter import apsc_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   input  logic [TIME_W-1:0]             req_timestamp_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [COUNT_W-1:0]            rsp_step_total,
   output logic                          rsp_step_now,
   output logic [SAMPLE_BITS-1:0]        rsp_filtered_magnitude,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   push_type         push;
   queue_status_type queue_status;
   sample_entry_type queue_head;
   logic             pop;

   apsc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .req_timestamp_ms (req_timestamp_ms),
      .push_out         (push),
      .queue_status     (queue_status)
   );

   apsc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .status  (queue_status),
      .head    (queue_head)
   );

   apsc_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .head                   (queue_head),
      .queue_status           (queue_status),
      .pop                    (pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_step_total         (rsp_step_total),
      .rsp_step_now           (rsp_step_now),
      .rsp_filtered_magnitude (rsp_filtered_magnitude)
   );

   `APSC_ASSERT_NEXT(a_front_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `APSC_ASSERT_NEXT(a_push_holds_when_full, clock, reset, push.valid && queue_status.full, push.valid && $stable(push.entry))
   `APSC_ASSERT_NEXT(a_back_busy_after_pop, clock, reset, pop, !pop)

endmodule
